FILE: sv/bis_pkg.sv
package bis_pkg;

    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;

    localparam logic [CNT_W-1:0] BP_COUNT_RESET = 7'd2;

    localparam logic OPC_WRITE  = 1'b0;
    localparam logic OPC_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] RS_IN    = 2'd0;
    localparam logic [STATUS_W-1:0] RS_BELOW = 2'd1;
    localparam logic [STATUS_W-1:0] RS_ABOVE = 2'd2;

    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID,
        RD_IDX,
        RD_IDX1
    } t_rd_sel;

    typedef struct packed {
        logic    load_query;
        logic    mem_wr;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_first;
        logic    cap_last;
        logic    range_chk;
        logic    bis_step;
        logic    fix_idx;
        logic    cap_b0;
        logic    cap_b1;
        logic    sub;
        logic    div_prep;
        logic    div_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic above;
        logic below;
        logic bis_done;
        logic frac_fixed;
    } t_sts;

endpackage

FILE: sv/breakpoint_index_search.sv
// write request: taken while idle, next request accepted in the following cycle
// search request: an out of range result goes from the first and last table reads
//   straight to the output; in range, each bisection step reads the midpoint through
//   the single registered table read port and then compares, and the serial divider
//   yields one fraction bit per cycle; one search at a time
// reset clears control state and sets bp_count to 2; the table is not cleared
module breakpoint_index_search #(
    parameter int TABLE_DEPTH   = 64,
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [bis_pkg::IDX_W-1:0]     i_bp_index,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bis_pkg::IDX_W-1:0]     o_left_index,
    output logic [FRACTION_BITS:0]        o_fraction,
    output logic [bis_pkg::STATUS_W-1:0]  o_range_status,
    input  logic                          i_cfg_we,
    input  logic [bis_pkg::CNT_W-1:0]     i_cfg_data
);

    bis_pkg::t_cmd cmd;
    bis_pkg::t_sts sts;

    bis_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    bis_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_bp_index     (i_bp_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_left_index   (o_left_index),
        .o_fraction     (o_fraction),
        .o_range_status (o_range_status)
    );

endmodule

FILE: sv/bis_dp.sv
module bis_dp #(
    parameter int TABLE_DEPTH   = 64,
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bis_pkg::t_cmd                       i_cmd,
    output bis_pkg::t_sts                       o_sts,
    input  logic [bis_pkg::IDX_W-1:0]           i_bp_index,
    input  logic signed [VALUE_WIDTH-1:0]       i_value,
    input  logic                                i_cfg_we,
    input  logic [bis_pkg::CNT_W-1:0]           i_cfg_data,
    output logic [bis_pkg::IDX_W-1:0]           o_left_index,
    output logic [FRACTION_BITS:0]              o_fraction,
    output logic [bis_pkg::STATUS_W-1:0]        o_range_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int W  = VALUE_WIDTH;
    localparam int FW = FRACTION_BITS + 1;
    localparam int CW = bis_pkg::CNT_W;
    localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic signed [W-1:0] mem [0:TABLE_DEPTH-1];

    logic [CW-1:0]       r_bp_count;
    logic signed [W-1:0] r_rd_data;
    logic signed [W-1:0] r_u;
    logic signed [W-1:0] r_first;
    logic signed [W-1:0] r_last;
    logic signed [W-1:0] r_b0;
    logic signed [W-1:0] r_b1;
    logic [CW-1:0]       r_n;
    logic                r_asc;
    logic [CW-1:0]       r_lo1;
    logic [CW-1:0]       r_hi;
    logic [CW-1:0]       r_idx;
    logic [FW-1:0]       r_frac;
    logic [bis_pkg::STATUS_W-1:0] r_status;
    logic                r_zero;
    logic [W-1:0]        r_num;
    logic [W-1:0]        r_den;
    logic [W-1:0]        r_rem;
    logic [bis_pkg::IDX_W-1:0]    r_left_index;
    logic [FW-1:0]                r_fraction;
    logic [bis_pkg::STATUS_W-1:0] r_range_status;

    logic [CW-1:0] n_clamp;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [AW-1:0] rd_addr;
    logic          wr_ok;
    logic          asc_now;
    logic          go_right;
    logic [CW-1:0] idx_raw;
    logic [CW-1:0] idx_max;
    logic [W:0]    twice;
    logic          ge;

    always_comb begin
        if (r_bp_count < bis_pkg::BP_COUNT_RESET) begin
            n_clamp = bis_pkg::BP_COUNT_RESET;
        end else if (32'(r_bp_count) > 32'(TABLE_DEPTH)) begin
            n_clamp = CW'(TABLE_DEPTH);
        end else begin
            n_clamp = r_bp_count;
        end
    end

    // midpoint of (lo, hi) with lo kept as lo + 1
    assign mid_sum = {1'b0, r_hi} + {1'b0, r_lo1} - (CW+1)'(1);
    assign mid     = mid_sum[CW:1];

    always_comb begin
        case (i_cmd.rd_sel)
            bis_pkg::RD_FIRST: rd_addr = '0;
            bis_pkg::RD_LAST:  rd_addr = AW'(r_n - CW'(1));
            bis_pkg::RD_MID:   rd_addr = AW'(mid);
            bis_pkg::RD_IDX:   rd_addr = AW'(r_idx);
            bis_pkg::RD_IDX1:  rd_addr = AW'(r_idx + CW'(1));
            default:           rd_addr = '0;
        endcase
    end

    assign wr_ok = 32'(i_bp_index) < 32'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && wr_ok) begin
            mem[AW'(i_bp_index)] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign asc_now  = r_last > r_first;
    assign go_right = (r_u > r_rd_data) == r_asc;

    always_comb begin
        idx_max = r_n - CW'(2);
        if (r_lo1 == '0 || (r_asc && r_u == r_first)) begin
            idx_raw = '0;
        end else begin
            idx_raw = r_lo1 - CW'(1);
        end
    end

    assign twice = {r_rem, 1'b0};
    assign ge    = twice >= {1'b0, r_den};

    assign o_sts.above      = (r_u > r_last) == asc_now;
    assign o_sts.below      = (r_u < r_first) == asc_now;
    assign o_sts.bis_done   = !(r_hi > r_lo1);
    assign o_sts.frac_fixed = r_zero || (r_num >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_count <= bis_pkg::BP_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_bp_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_u <= i_value;
            r_n <= n_clamp;
        end
        if (i_cmd.cap_first) begin
            r_first <= r_rd_data;
        end
        if (i_cmd.cap_last) begin
            r_last <= r_rd_data;
        end
        if (i_cmd.range_chk) begin
            r_asc  <= asc_now;
            r_lo1  <= '0;
            r_hi   <= r_n;
            r_frac <= '0;
            if (o_sts.above) begin
                r_idx    <= r_n - CW'(1);
                r_status <= bis_pkg::RS_ABOVE;
            end else if (o_sts.below) begin
                r_idx    <= '0;
                r_status <= bis_pkg::RS_BELOW;
            end else begin
                r_status <= bis_pkg::RS_IN;
            end
        end
        if (i_cmd.bis_step) begin
            if (go_right) begin
                r_lo1 <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.fix_idx) begin
            r_idx <= (idx_raw > idx_max) ? idx_max : idx_raw;
        end
        if (i_cmd.cap_b0) begin
            r_b0 <= r_rd_data;
        end
        if (i_cmd.cap_b1) begin
            r_b1 <= r_rd_data;
        end
        if (i_cmd.sub) begin
            if (r_b1 > r_b0) begin
                r_zero <= r_u <= r_b0;
                r_num  <= W'(r_u - r_b0);
                r_den  <= W'(r_b1 - r_b0);
            end else if (r_b1 < r_b0) begin
                r_zero <= r_u >= r_b0;
                r_num  <= W'(r_b0 - r_u);
                r_den  <= W'(r_b0 - r_b1);
            end else begin
                // flat segment
                r_zero <= 1'b1;
                r_num  <= '0;
                r_den  <= '0;
            end
        end
        if (i_cmd.div_prep) begin
            r_rem <= r_num;
            if (!r_zero && r_num >= r_den) begin
                r_frac <= FRAC_ONE;
            end else begin
                r_frac <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? W'(twice - {1'b0, r_den}) : W'(twice);
            r_frac <= {r_frac[FW-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_left_index   <= bis_pkg::IDX_W'(r_idx);
            r_fraction     <= r_frac;
            r_range_status <= r_status;
        end
    end

    assign o_left_index   = r_left_index;
    assign o_fraction     = r_fraction;
    assign o_range_status = r_range_status;

endmodule

FILE: sv/bis_ctrl.sv
module bis_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_opcode,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output bis_pkg::t_cmd o_cmd,
    input  bis_pkg::t_sts i_sts
);

    localparam int CW = $clog2(FRACTION_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_CAPL,
        S_RANGE,
        S_BRD,
        S_BCMP,
        S_FIX,
        S_RB0,
        S_RB1,
        S_B1,
        S_SUB,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == bis_pkg::OPC_SEARCH) begin
                        o_cmd.load_query = 1'b1;
                        o_cmd.rd_en      = 1'b1;
                        o_cmd.rd_sel     = bis_pkg::RD_FIRST;
                        n_state          = S_LAST;
                    end else begin
                        o_cmd.mem_wr = 1'b1;
                    end
                end
            end
            S_LAST: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = bis_pkg::RD_LAST;
                o_cmd.cap_first = 1'b1;
                n_state         = S_CAPL;
            end
            S_CAPL: begin
                o_cmd.cap_last = 1'b1;
                n_state        = S_RANGE;
            end
            S_RANGE: begin
                o_cmd.range_chk = 1'b1;
                n_state = (i_sts.above || i_sts.below) ? S_DONE : S_BRD;
            end
            S_BRD: begin
                if (i_sts.bis_done) begin
                    n_state = S_FIX;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bis_pkg::RD_MID;
                    n_state      = S_BCMP;
                end
            end
            S_BCMP: begin
                o_cmd.bis_step = 1'b1;
                n_state        = S_BRD;
            end
            S_FIX: begin
                o_cmd.fix_idx = 1'b1;
                n_state       = S_RB0;
            end
            S_RB0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bis_pkg::RD_IDX;
                n_state      = S_RB1;
            end
            S_RB1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bis_pkg::RD_IDX1;
                o_cmd.cap_b0 = 1'b1;
                n_state      = S_B1;
            end
            S_B1: begin
                o_cmd.cap_b1 = 1'b1;
                n_state      = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_cnt          = CW'(FRACTION_BITS - 1);
                n_state        = i_sts.frac_fixed ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;

endmodule
